/* src/ledd_pkg.sv */
package ledd_pkg;

  localparam int BITS_PER_WORD = 24;
  localparam int LED_CNT_W     = 9;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  localparam logic [BITS_PER_WORD-1:0] TEST_PATTERN = 24'h555555;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_LEDS   = 3'd4;

  typedef struct packed {
    logic [9:0]           bit_period;
    logic [9:0]           zero_high;
    logic [9:0]           one_high;
    logic [15:0]          blank_ticks;
    logic [LED_CNT_W-1:0] num_leds;
  } ledd_cfg_t;

  localparam ledd_cfg_t CFG_RESET = '{
    bit_period:  10'd90,
    zero_high:   10'd30,
    one_high:    10'd60,
    blank_ticks: 16'd3960,
    num_leds:    9'd256
  };

  typedef struct packed {
    logic frame_start;
    logic blanking;
    logic pin_level;
  } ledd_res_t;

  // rgb in, grb send order out
  function automatic logic [BITS_PER_WORD-1:0] to_send_order(
    input logic [BITS_PER_WORD-1:0] rgb
  );
    return {rgb[15:8], rgb[23:16], rgb[7:0]};
  endfunction

endpackage

/* src/ledd_ram.sv */
module ledd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/ledd_pixel_store.sv */
module ledd_pixel_store import ledd_pkg::*; #(
  parameter int MAX_LEDS = 256,
  parameter int LW       = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [LW-1:0]            waddr,
  input  logic [BITS_PER_WORD-1:0] wdata,
  input  logic [LW-1:0]            raddr,
  output logic [BITS_PER_WORD-1:0] word
);

  logic [MAX_LEDS-1:0]      valid_r;
  logic                     rd_vld_r;
  logic                     fwd_r;
  logic [BITS_PER_WORD-1:0] fwd_data_r;
  logic [BITS_PER_WORD-1:0] ram_rdata;

  ledd_ram #(
    .WIDTH(BITS_PER_WORD),
    .DEPTH(MAX_LEDS),
    .AW   (LW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rd_vld_r <= valid_r[raddr];
      // ram reads old data when the same entry is written
      fwd_r    <= we && (waddr == raddr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= wdata;
  end

  // entries never written still show the test pattern
  assign word = fwd_r    ? fwd_data_r :
                rd_vld_r ? ram_rdata  : TEST_PATTERN;

endmodule

/* src/ledd_timing.sv */
module ledd_timing import ledd_pkg::*; #(
  parameter int MAX_LEDS = 256,
  parameter int LW       = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     tick,
  input  ledd_cfg_t                cfg,
  input  logic [BITS_PER_WORD-1:0] word,
  output ledd_res_t                res,
  output logic [LW-1:0]            led_pos_nxt
);

  localparam int EW = ((LW + 1) > LED_CNT_W) ? (LW + 1) : LED_CNT_W;

  logic [9:0]    phase_r, phase_nxt;
  logic [4:0]    bit_r, bit_nxt;
  logic [LW-1:0] led_r, led_nxt;
  logic [15:0]   blank_cnt_r, blank_cnt_nxt;
  logic          in_blank_r, in_blank_nxt;

  logic [EW-1:0] led_cnt_ext;
  logic [EW-1:0] eff_leds;
  logic [EW-1:0] led_inc;
  logic [10:0]   phase_inc;
  logic [4:0]    bit_inc;
  logic [16:0]   blank_inc;
  logic          bit_val;
  logic [9:0]    high_ticks;

  assign bit_val    = word[5'(BITS_PER_WORD - 1) - bit_r];
  assign high_ticks = bit_val ? cfg.one_high : cfg.zero_high;

  assign res.pin_level   = !in_blank_r && (phase_r < high_ticks);
  assign res.blanking    = in_blank_r;
  assign res.frame_start = !in_blank_r && (led_r == '0) && (bit_r == '0) && (phase_r == '0);

  assign led_cnt_ext = EW'(cfg.num_leds);
  assign eff_leds    = (led_cnt_ext == '0)          ? EW'(1) :
                       (led_cnt_ext > EW'(MAX_LEDS)) ? EW'(MAX_LEDS) : led_cnt_ext;
  assign led_inc     = EW'(led_r) + EW'(1);
  assign phase_inc   = {1'b0, phase_r} + 11'd1;
  assign bit_inc     = bit_r + 5'd1;
  assign blank_inc   = {1'b0, blank_cnt_r} + 17'd1;

  always_comb begin
    phase_nxt     = phase_r;
    bit_nxt       = bit_r;
    led_nxt       = led_r;
    blank_cnt_nxt = blank_cnt_r;
    in_blank_nxt  = in_blank_r;
    if (tick) begin
      if (in_blank_r) begin
        if (blank_inc >= {1'b0, cfg.blank_ticks}) begin
          in_blank_nxt  = 1'b0;
          blank_cnt_nxt = '0;
        end else begin
          blank_cnt_nxt = blank_inc[15:0];
        end
      end else if (phase_inc < {1'b0, cfg.bit_period}) begin
        phase_nxt = phase_inc[9:0];
      end else begin
        phase_nxt = '0;
        if (bit_inc < 5'(BITS_PER_WORD)) begin
          bit_nxt = bit_inc;
        end else begin
          bit_nxt = '0;
          if (led_inc < eff_leds) begin
            led_nxt = led_inc[LW-1:0];
          end else begin
            // end of frame, latch period unless it is zero long
            led_nxt       = '0;
            blank_cnt_nxt = '0;
            in_blank_nxt  = (cfg.blank_ticks != '0);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      bit_r       <= '0;
      led_r       <= '0;
      blank_cnt_r <= '0;
      in_blank_r  <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      bit_r       <= bit_nxt;
      led_r       <= led_nxt;
      blank_cnt_r <= blank_cnt_nxt;
      in_blank_r  <= in_blank_nxt;
    end
  end

  // store read is addressed with the next position, so its word lines up with the position register
  assign led_pos_nxt = led_nxt;

endmodule

/* src/addressable_led_strip_driver_unit.sv */
// channel | dir | tdata (low bit up)                 | tuser    | rate
// in_     | in  | led_index[7:0], color[31:8]        | req_type | 1 per cycle unless out_ stalls
// out_    | out | pin_level, blanking, frame_start, 0 | -        | 1 per item
// cfg_    | in  | write only, index selects register | -        | any cycle when idle
//
// one transfer in and one result out per cycle in steady state, while out_tready stays high
// a transfer passes the input register, then the result register
// the pixel store ram has one write and one read port; the read is addressed with the next position
// reset clears valid bits for all entries at once, no clearing pass
// a stalled result holds while the input stage still takes one more transfer
module addressable_led_strip_driver_unit import ledd_pkg::*; #(
  parameter int MAX_LEDS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // led_index[7:0], color[31:8]
  input  logic                  in_tuser,   // req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // pin_level, blanking, frame_start, zero fill
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  ledd_cfg_t cfg_r;

  logic        s1_vld_r;
  logic        s1_req_r;
  logic [7:0]  s1_idx_r;
  logic [23:0] s1_color_r;
  logic        s1_fire;

  logic      out_vld_r;
  ledd_res_t out_res_r;
  ledd_res_t res;
  ledd_res_t res_item;

  logic                     wr_en;
  logic [BITS_PER_WORD-1:0] word;
  logic [LW-1:0]            led_pos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIT_PERIOD: cfg_r.bit_period  <= cfg_data[9:0];
        REG_ZERO_HIGH:  cfg_r.zero_high   <= cfg_data[9:0];
        REG_ONE_HIGH:   cfg_r.one_high    <= cfg_data[9:0];
        REG_BLANK:      cfg_r.blank_ticks <= cfg_data;
        REG_NUM_LEDS:   cfg_r.num_leds    <= cfg_data[LED_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_fire   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_req_r   <= in_tuser;
      s1_idx_r   <= in_tdata[7:0];
      s1_color_r <= in_tdata[31:8];
    end
  end

  // indices beyond the store are dropped
  assign wr_en = s1_fire && s1_req_r && (32'(s1_idx_r) < 32'(MAX_LEDS));

  ledd_pixel_store #(
    .MAX_LEDS(MAX_LEDS),
    .LW      (LW)
  ) u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (wr_en),
    .waddr(LW'(s1_idx_r)),
    .wdata(to_send_order(s1_color_r)),
    .raddr(led_pos_nxt),
    .word (word)
  );

  ledd_timing #(
    .MAX_LEDS(MAX_LEDS),
    .LW      (LW)
  ) u_timing (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (s1_fire && !s1_req_r),
    .cfg        (cfg_r),
    .word       (word),
    .res        (res),
    .led_pos_nxt(led_pos_nxt)
  );

  // a set transfer lets no time pass
  always_comb begin
    res_item = res;
    if (s1_req_r) begin
      res_item.frame_start = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res_item;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b0, out_res_r.frame_start, out_res_r.blanking, out_res_r.pin_level};

endmodule

/* src/ledd_checker.sv */
module ledd_checker import ledd_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [31:0]           in_tdata,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [7:0]            out_tdata,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  logic unused_ok;
  assign unused_ok = ^{in_tvalid, in_tready, in_tdata, in_tuser, cfg_we, cfg_index, cfg_data};

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_blank_pin_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> !out_tdata[0])
    else $error("pin high during latch period");

  a_start_not_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> !out_tdata[1])
    else $error("frame start inside latch period");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind addressable_led_strip_driver_unit ledd_checker u_ledd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);
